// ===== rtl/crc32_hash_bucket_index_core_assert.svh =====
// Assertion macros shared by the hash core RTL.
`ifndef CRC32_HASH_BUCKET_INDEX_CORE_ASSERT_SVH
`define CRC32_HASH_BUCKET_INDEX_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Clocked on aclk, masked while aresetn is low.
`define CRCHB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("crc32 hash core: assertion failed");
// Condition in one cycle implies expression in the next.
`define CRCHB_ASSERT_NEXT(lbl, cond, expr) `CRCHB_ASSERT(lbl, (cond) |=> (expr))
`else
`define CRCHB_ASSERT(lbl, prop)
`define CRCHB_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

// ===== rtl/crchb_pkg.sv =====
// Shared types and constants of the CRC-32 hash and bucket index core.
package crchb_pkg;

    // Reflected CRC polynomial
    localparam logic [31:0] CRC_POLY = 32'hF3C5_F6A9;

    // CRC digit size and digits per byte
    localparam int DIGIT_W   = 2;
    localparam int DIGITS    = 8 / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(DIGITS);

    // Shared restoring divider: 33-bit numerator and divisor
    localparam int DIV_W     = 33;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HASH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_EXTEND  = 2'd2;

    // Control states of the core
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEN,
        ST_CRC,
        ST_HASH,
        ST_DIV,
        ST_LOAD
    } state_t;

    // Division request into the shared divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } div_req_t;

endpackage

// ===== rtl/crchb_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`include "crc32_hash_bucket_index_core_assert.svh"

module crchb_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  crchb_pkg::div_req_t       req,
    output logic                      busy,
    output logic [crchb_pkg::DIV_W-1:0] quo
);

    logic [crchb_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [crchb_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [crchb_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [crchb_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [crchb_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [crchb_pkg::DIV_W:0]       trial;
    logic                            fits;

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

    // One shift-compare-subtract step
    always_comb begin
        trial    = {rem_reg, num_reg[crchb_pkg::DIV_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (req.start) begin
            cnt_next = crchb_pkg::DIV_CNT_W'(crchb_pkg::DIV_STEPS);
            num_next = req.num;
            den_next = req.den;
            rem_next = '0;
        end else if (busy) begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[crchb_pkg::DIV_W-2:0], 1'b0};
            rem_next = fits ? crchb_pkg::DIV_W'(trial - {1'b0, den_reg})
                            : trial[crchb_pkg::DIV_W-1:0];
            quo_next = {quo_reg[crchb_pkg::DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Step counter stays in range and a new request never lands mid-division
    `CRCHB_ASSERT(a_cnt_range, cnt_reg <= crchb_pkg::DIV_CNT_W'(crchb_pkg::DIV_STEPS))
    `CRCHB_ASSERT(a_no_restart, req.start |-> !busy)
    `CRCHB_ASSERT_NEXT(a_start_busy, req.start, busy)

endmodule

// ===== rtl/crc32_hash_bucket_index_core.sv =====
// CRC-32 key hasher with bucket index: top level.
// Each key byte is accepted in ST_IDLE, then ST_CRC folds it in as four digits, the CRC advancing 2 bits per cycle.
// After the last byte, ST_HASH issues the divide, ST_DIV waits out the bit-serial divider and ST_LOAD loads the result.
// A write to bucket_count (and reset) starts a divisor computation that keeps s_tready
// low until it ends; the first key after reset waits for it.
// Reset is synchronous, active low; the result register frees the input side.
`include "crc32_hash_bucket_index_core_assert.svh"

module crc32_hash_bucket_index_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [crchb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_wdata,
    // key byte stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,   // last_byte
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata    // [31:0] hash_value, [47:32] bucket_index
);

    crchb_pkg::state_t   state_reg, state_next;
    crchb_pkg::div_req_t div_req;
    logic                div_busy;
    logic [crchb_pkg::DIV_W-1:0] div_quo;

    logic [31:0] init_hash_reg;
    logic [15:0] bucket_cnt_reg;
    logic        sext_reg;
    logic        den_stale_reg, den_stale_next;
    logic [crchb_pkg::DIV_W-1:0] den_reg, den_next;

    logic [31:0] crc_reg, crc_next;
    logic [crchb_pkg::DIG_CNT_W-1:0] dig_reg, dig_next;
    logic        last_reg, last_next;
    logic        key_reg, key_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] hash_out_reg, hash_out_next;
    logic [15:0] bucket_out_reg, bucket_out_next;

    logic        s_accept;
    logic        out_load;
    logic        dig_last;
    logic [15:0] count_eff;
    logic [15:0] count_m1;
    logic [31:0] crc_base;
    logic [31:0] byte_ext;

    // Advance a reflected CRC by one digit
    function automatic logic [31:0] crc_digit(input logic [31:0] c);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < crchb_pkg::DIGIT_W; k++) begin
            r = r[0] ? ((r >> 1) ^ crchb_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    crchb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .quo     (div_quo)
    );

    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {bucket_out_reg, hash_out_reg};

    // Final digit of the current byte
    assign dig_last  = (dig_reg == crchb_pkg::DIG_CNT_W'(crchb_pkg::DIGITS - 1));

    // Zero buckets behave as one; divisor = (2^32 + n - 1) / n
    assign count_eff = (bucket_cnt_reg == 16'd0) ? 16'd1 : bucket_cnt_reg;
    assign count_m1  = count_eff - 16'd1;

    // Byte folded into the CRC at acceptance
    assign crc_base = key_reg ? crc_reg : init_hash_reg;
    assign byte_ext = {{24{sext_reg && s_tdata[7]}}, s_tdata};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_hash_reg  <= '0;
            bucket_cnt_reg <= 16'd1;
            sext_reg       <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                crchb_pkg::CFG_INITIAL_HASH: init_hash_reg  <= cfg_wdata;
                crchb_pkg::CFG_BUCKET_COUNT: bucket_cnt_reg <= cfg_wdata[15:0];
                crchb_pkg::CFG_SIGN_EXTEND:  sext_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Control FSM, CRC digit shifter and result register
    always_comb begin
        state_next      = state_reg;
        den_stale_next  = den_stale_reg;
        den_next        = den_reg;
        crc_next        = crc_reg;
        dig_next        = dig_reg;
        last_next       = last_reg;
        key_next        = key_reg;
        m_valid_next    = m_valid_reg;
        hash_out_next   = hash_out_reg;
        bucket_out_next = bucket_out_reg;
        s_tready        = 1'b0;
        out_load        = 1'b0;
        div_req.start   = 1'b0;
        div_req.num     = {1'b0, crc_reg};
        div_req.den     = den_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            crchb_pkg::ST_IDLE: begin
                s_tready = !den_stale_reg;
                if (den_stale_reg) begin
                    div_req.start  = 1'b1;
                    div_req.num    = {1'b1, 16'd0, count_m1};
                    div_req.den    = {17'd0, count_eff};
                    den_stale_next = 1'b0;
                    state_next     = crchb_pkg::ST_DEN;
                end else if (s_accept) begin
                    crc_next   = crc_base ^ byte_ext;
                    dig_next   = '0;
                    last_next  = s_tlast;
                    key_next   = !s_tlast;
                    state_next = crchb_pkg::ST_CRC;
                end
            end
            crchb_pkg::ST_DEN: begin
                if (!div_busy) begin
                    den_next   = div_quo;
                    state_next = crchb_pkg::ST_IDLE;
                end
            end
            crchb_pkg::ST_CRC: begin
                crc_next = crc_digit(crc_reg);
                dig_next = dig_reg + 1'b1;
                if (dig_last) begin
                    state_next = last_reg ? crchb_pkg::ST_HASH : crchb_pkg::ST_IDLE;
                end
            end
            crchb_pkg::ST_HASH: begin
                div_req.start = 1'b1;
                state_next    = crchb_pkg::ST_DIV;
            end
            crchb_pkg::ST_DIV: begin
                if (!div_busy) begin
                    state_next = crchb_pkg::ST_LOAD;
                end
            end
            crchb_pkg::ST_LOAD: begin
                if (!m_valid_reg || m_tready) begin
                    out_load        = 1'b1;
                    m_valid_next    = 1'b1;
                    hash_out_next   = crc_reg;
                    bucket_out_next = div_quo[15:0];
                    state_next      = crchb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crchb_pkg::ST_IDLE;
            end
        endcase

        // A new bucket count invalidates the divisor
        if (cfg_wr_en && (cfg_index == crchb_pkg::CFG_BUCKET_COUNT)) begin
            den_stale_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crchb_pkg::ST_IDLE;
            den_stale_reg <= 1'b1;
            key_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            den_stale_reg <= den_stale_next;
            key_reg       <= key_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg        <= den_next;
        crc_reg        <= crc_next;
        dig_reg        <= dig_next;
        last_reg       <= last_next;
        hash_out_reg   <= hash_out_next;
        bucket_out_reg <= bucket_out_next;
    end

    // Divider is free whenever bytes can be taken
    `CRCHB_ASSERT(a_idle_div_free, (state_reg == crchb_pkg::ST_IDLE) |-> !div_busy)
    // A byte leaves ST_CRC after its final digit
    `CRCHB_ASSERT_NEXT(a_crc_done, (state_reg == crchb_pkg::ST_CRC) && dig_last, state_reg != crchb_pkg::ST_CRC)
    // A result appears only from the load step
    `CRCHB_ASSERT(a_result_src, $rose(m_valid_reg) |-> $past(out_load))
    // Loading never overwrites an untaken result
    `CRCHB_ASSERT(a_no_overwrite, out_load |-> (!m_valid_reg || m_tready))

endmodule

// ===== tb/crc32_hash_bucket_index_core_chk.sv =====
// Checker for the CRC-32 hash core: tracks config, predicts each key's hash and bucket, compares.
module crc32_hash_bucket_index_core_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [crchb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  logic                            s_tlast,   // last_byte
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [47:0]                     m_tdata,   // [31:0] hash_value, [47:32] bucket_index
    output int                              errors,
    output int                              pending
);

    localparam logic [31:0] KEY_POLY = 32'hF3C5_F6A9;

    typedef struct {
        logic [31:0] hash;
        logic [15:0] bucket;
    } key_result_t;

    // Mirror of the config registers and the running key state
    logic [31:0]  seed_hash;
    logic [15:0]  n_buckets;
    logic         sext_on;
    logic [31:0]  key_crc;
    logic         in_key;
    key_result_t  expected_keys[$];

    // One byte through the reflected CRC, LSB first
    function automatic logic [31:0] crc_after_byte(logic [31:0] crc, logic [7:0] b, logic sx);
        logic [31:0] v;
        logic [31:0] t;
        int k;
        v = {{24{sx & b[7]}}, b};
        crc = crc ^ v;
        t = {24'd0, crc[7:0]};
        for (k = 0; k < 8; k++) begin
            if (t[0]) t = (t >> 1) ^ KEY_POLY;
            else      t = t >> 1;
        end
        return (crc >> 8) ^ t;
    endfunction

    // hash / ceil(2^32 / count); a zero count acts as one bucket
    function automatic logic [15:0] bucket_for(logic [31:0] h, logic [15:0] n);
        logic [63:0] cnt;
        logic [63:0] den;
        logic [63:0] q;
        cnt = (n == 16'd0) ? 64'd1 : {48'd0, n};
        den = (64'h1_0000_0000 + cnt - 64'd1) / cnt;
        q   = {32'd0, h} / den;
        return q[15:0];
    endfunction

    always @(posedge aclk) begin
        key_result_t exp_r;
        logic [31:0] got_hash;
        logic [15:0] got_bucket;
        if (!aresetn) begin
            errors    = 0;
            seed_hash = 32'd0;
            n_buckets = 16'd1;
            sext_on   = 1'b1;
            key_crc   = 32'd0;
            in_key    = 1'b0;
            expected_keys.delete();
        end else begin
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    crchb_pkg::CFG_INITIAL_HASH: seed_hash = cfg_wdata;
                    crchb_pkg::CFG_BUCKET_COUNT: n_buckets = cfg_wdata[15:0];
                    crchb_pkg::CFG_SIGN_EXTEND:  sext_on   = cfg_wdata[0];
                    default: ;
                endcase
            end
            // result compare against the oldest key
            if (m_tvalid && m_tready) begin
                got_hash   = m_tdata[31:0];
                got_bucket = m_tdata[47:32];
                if (expected_keys.size() == 0) begin
                    $display("%0t: unexpected result, hash %h bucket %0d",
                             $time, got_hash, got_bucket);
                    errors++;
                end else begin
                    exp_r = expected_keys.pop_front();
                    if (got_hash !== exp_r.hash) begin
                        $display("%0t: hash_value mismatch: expected %h, actual %h",
                                 $time, exp_r.hash, got_hash);
                        errors++;
                    end
                    if (got_bucket !== exp_r.bucket) begin
                        $display("%0t: bucket_index mismatch: expected %0d, actual %0d",
                                 $time, exp_r.bucket, got_bucket);
                        errors++;
                    end
                end
            end
            // byte request: advance the key, queue a result on the last byte
            if (s_tvalid && s_tready) begin
                if (!in_key) key_crc = seed_hash;
                key_crc = crc_after_byte(key_crc, s_tdata, sext_on);
                if (s_tlast) begin
                    exp_r.hash   = key_crc;
                    exp_r.bucket = bucket_for(key_crc, n_buckets);
                    expected_keys.push_back(exp_r);
                    in_key = 1'b0;
                end else begin
                    in_key = 1'b1;
                end
            end
        end
        pending = expected_keys.size();
    end

endmodule

// ===== tb/crc32_hash_bucket_index_core_tb.sv =====
// Testbench top for the CRC-32 hash core: clock, reset, stimulus, receiver and verdict.
module crc32_hash_bucket_index_core_tb;

    localparam int DRAIN_CYCLES = 80;   // last byte plus divide, with margin
    localparam int HOLD_CYCLES  = 400;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [crchb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                     cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;   // [7:0] data_byte
    logic                            s_tlast;   // last_byte
    logic                            m_tvalid;
    logic                            m_tready;
    logic [47:0]                     m_tdata;   // [31:0] hash_value, [47:32] bucket_index
    int                              errors;
    int                              pending;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_seq        = 0;

    crc32_hash_bucket_index_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    crc32_hash_bucket_index_core_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_seq != hold_seen) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_seq;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic cfg_write(input logic [crchb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // offer one key byte and wait for its request to be taken
    task automatic send_key_byte(input logic [7:0] b, input logic lst);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending, wait for every outstanding result, then let the core settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_config(input logic [31:0] seed, input logic [15:0] nb, input logic sx);
        cfg_write(crchb_pkg::CFG_INITIAL_HASH, seed);
        cfg_write(crchb_pkg::CFG_BUCKET_COUNT, {16'd0, nb});
        cfg_write(crchb_pkg::CFG_SIGN_EXTEND, {31'd0, sx});
    endtask

    // random keys, mostly short, now and then long
    task automatic send_random_keys(input int n_bytes);
        int sent;
        int len;
        int i;
        sent = 0;
        while (sent < n_bytes) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            if (len > n_bytes - sent) len = n_bytes - sent;
            for (i = 0; i < len; i++)
                send_key_byte(8'($urandom_range(0, 255)), i == len - 1);
            sent += len;
        end
    endtask

    // stimulus and verdict
    initial begin
        int ph;
        logic [31:0] seed;
        logic [15:0] nb;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = crchb_pkg::CFG_INITIAL_HASH;
        cfg_wdata = 32'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tlast   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: byte extremes, single-byte and multi-byte keys
        send_key_byte(8'h00, 1'b1);
        send_key_byte(8'hFF, 1'b1);
        send_key_byte(8'h80, 1'b1);
        send_key_byte(8'h7F, 1'b1);
        send_key_byte(8'h01, 1'b0);
        send_key_byte(8'hFE, 1'b0);
        send_key_byte(8'h55, 1'b0);
        send_key_byte(8'hAA, 1'b1);
        drain_results();

        // zero-extended bytes, zero bucket count acting as one, all-ones seed
        set_config(32'hFFFF_FFFF, 16'd0, 1'b0);
        send_key_byte(8'hFF, 1'b1);
        send_key_byte(8'h80, 1'b1);
        send_key_byte(8'h00, 1'b0);
        send_key_byte(8'h7F, 1'b1);
        drain_results();

        // largest bucket count
        set_config(32'h0000_0000, 16'hFFFF, 1'b1);
        send_key_byte(8'hFF, 1'b0);
        send_key_byte(8'hFF, 1'b0);
        send_key_byte(8'hFF, 1'b0);
        send_key_byte(8'hFF, 1'b1);
        drain_results();

        // seed rewritten while a key is open: only the next key sees it
        send_key_byte(8'h3C, 1'b0);
        drain_results();
        cfg_write(crchb_pkg::CFG_INITIAL_HASH, 32'h1234_5678);
        send_key_byte(8'hC3, 1'b1);
        send_key_byte(8'hA5, 1'b1);
        drain_results();

        set_config(32'h0000_0000, 16'd2, 1'b1);
        send_key_byte(8'h80, 1'b1);
        send_key_byte(8'h11, 1'b1);
        drain_results();

        // random phases over idle patterns and settings
        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin seed = 32'd0;          nb = 16'd1;    end
                1: begin seed = 32'hFFFF_FFFF;  nb = 16'hFFFF; end
                2: begin seed = $urandom();     nb = 16'd0;    end
                5: begin seed = $urandom();     nb = 16'd2;    end
                default: begin
                    seed = $urandom();
                    nb   = 16'($urandom_range(1, 65535));
                end
            endcase
            set_config(seed, nb,
                       (ph % 2 == 1) ? 1'b1 : ((ph >= 4) ? 1'($urandom_range(0, 1)) : 1'b0));
            case (ph % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            // long result hold-off while bytes keep coming
            if (ph == 0) hold_seq++;
            send_random_keys(160);
            drain_results();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
